### rtl/broadcast_source_record_validator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the source record validator.
// Each macro expects clk, and BSRV_ASSERT also rst_n, to be visible in scope.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_SOURCE_RECORD_VALIDATOR_TOP_DEFINES_SVH
`define BROADCAST_SOURCE_RECORD_VALIDATOR_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BSRV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BSRV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bsrv_pkg.sv
// ----------------------------------------------------------------------------
// bsrv_pkg
// Types and constants shared by the source record validator.
// ----------------------------------------------------------------------------
package bsrv_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_SYNC0  = 4'd1,
        PH_SYNC1  = 4'd2,
        PH_SYNC2  = 4'd3,
        PH_SYNC3  = 4'd4,
        PH_MDLEN  = 4'd5,
        PH_META   = 4'd6,
        PH_DONE   = 4'd7
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_ADDR_TYPE = 4'd2,
        ERR_SID       = 4'd3,
        ERR_PA_SYNC   = 4'd4,
        ERR_SUBGROUPS = 4'd5,
        ERR_OVERLAP   = 4'd6,
        ERR_TRUNCATED = 4'd7,
        ERR_MD_OVERRUN = 4'd8,
        ERR_LENGTH    = 4'd9
    } err_t;

    typedef enum logic [1:0] {
        REG_MAX_ADDR_TYPE = 2'd0,
        REG_FIRST_RSV_PA  = 2'd1,
        REG_MAX_SUBGROUPS = 2'd2
    } reg_idx_t;

    localparam int unsigned MIN_LEN = 15;
    localparam int unsigned IDX_ADDR_TYPE = 0;
    localparam int unsigned IDX_SID = 7;
    localparam int unsigned IDX_PA_SYNC = 11;
    localparam int unsigned IDX_NUM_SUBGROUPS = 14;

    localparam logic [7:0]  SID_MAX  = 8'h0F;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [7:0] RST_MAX_ADDR_TYPE = 8'd1;
    localparam logic [7:0] RST_FIRST_RSV_PA  = 8'd5;
    localparam logic [5:0] RST_MAX_SUBGROUPS = 6'd4;

endpackage

### rtl/broadcast_source_record_validator_top.sv
// ----------------------------------------------------------------------------
// broadcast_source_record_validator_top
// Checks an add-source record streamed one byte per transaction and returns
// one verdict with an error code for each record.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  input   | in        | in_valid / in_stall  | data_byte, last_byte
//  output  | out       | out_valid / out_stall| accepted, error_code
//  config  | in        | cfg_we               | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the field-phase update
// between the input register and the result register keeps that rate.
// A verdict is registered as its record's last byte leaves the input register.
// Reset returns the record state and the registers to their defaults at once.
// A stalled verdict holds up a last byte and those behind it; others flow on.
// ----------------------------------------------------------------------------
`include "broadcast_source_record_validator_top_defines.svh"

module broadcast_source_record_validator_top
    import bsrv_pkg::*;
#(
    parameter int unsigned MAX_LEN = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [3:0] error_code,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);

    logic [7:0]       max_addr_type_reg;
    logic [7:0]       first_rsv_pa_reg;
    logic [5:0]       max_subgroups_reg;

    logic             s0_valid_reg;
    logic [7:0]       s0_data_reg;
    logic             s0_last_reg;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       subgroups_left_reg, subgroups_left_next;
    logic [31:0]      sync_word_reg, sync_word_next;
    logic [31:0]      sync_union_reg, sync_union_next;
    logic [7:0]       metadata_left_reg, metadata_left_next;
    err_t             first_error_reg, first_error_next;

    logic             out_valid_reg;
    logic             accepted_reg;
    err_t             error_code_reg;

    logic             in_accept;
    logic             s0_advance;
    logic             s0_fire;
    logic [7:0]       sg_dec;
    logic [7:0]       md_dec;
    logic [31:0]      sync_full;
    err_t             verdict;

    assign s0_advance = !s0_last_reg || !out_valid_reg || !out_stall;
    assign s0_fire    = s0_valid_reg && s0_advance;
    assign in_stall   = s0_valid_reg && !s0_advance;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign error_code = error_code_reg;

    assign sg_dec    = (subgroups_left_reg != 8'd0) ? subgroups_left_reg - 8'd1
                                                    : subgroups_left_reg;
    assign md_dec    = (metadata_left_reg != 8'd0) ? metadata_left_reg - 8'd1
                                                   : metadata_left_reg;
    assign sync_full = {s0_data_reg, sync_word_reg[23:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_addr_type_reg <= RST_MAX_ADDR_TYPE;
            first_rsv_pa_reg  <= RST_FIRST_RSV_PA;
            max_subgroups_reg <= RST_MAX_SUBGROUPS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ADDR_TYPE: max_addr_type_reg <= cfg_data;
                REG_FIRST_RSV_PA:  first_rsv_pa_reg  <= cfg_data;
                REG_MAX_SUBGROUPS: max_subgroups_reg <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_fire)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_data_reg <= data_byte;
            s0_last_reg <= last_byte;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        subgroups_left_next = subgroups_left_reg;
        sync_word_next      = sync_word_reg;
        sync_union_next     = sync_union_reg;
        metadata_left_next  = metadata_left_reg;
        first_error_next    = first_error_reg;
        verdict             = ERR_NONE;

        if (byte_count_reg >= CNT_W'(MAX_LEN))
        begin
            if (first_error_reg == ERR_NONE)
            begin
                first_error_next = ERR_LENGTH;
            end
        end
        else if (first_error_reg == ERR_NONE)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (byte_count_reg == CNT_W'(IDX_ADDR_TYPE))
                    begin
                        if (s0_data_reg > max_addr_type_reg)
                        begin
                            first_error_next = ERR_ADDR_TYPE;
                        end
                    end
                    else if (byte_count_reg == CNT_W'(IDX_SID))
                    begin
                        if (s0_data_reg > SID_MAX)
                        begin
                            first_error_next = ERR_SID;
                        end
                    end
                    else if (byte_count_reg == CNT_W'(IDX_PA_SYNC))
                    begin
                        if (s0_data_reg >= first_rsv_pa_reg)
                        begin
                            first_error_next = ERR_PA_SYNC;
                        end
                    end
                    else if (byte_count_reg == CNT_W'(IDX_NUM_SUBGROUPS))
                    begin
                        if (s0_data_reg > {2'b00, max_subgroups_reg})
                        begin
                            first_error_next = ERR_SUBGROUPS;
                        end
                        else
                        begin
                            subgroups_left_next = s0_data_reg;
                            sync_union_next     = 32'd0;
                            sync_word_next      = 32'd0;
                            phase_next = (s0_data_reg == 8'd0) ? PH_DONE : PH_SYNC0;
                        end
                    end
                end
                PH_SYNC0:
                begin
                    sync_word_next = {24'd0, s0_data_reg};
                    phase_next     = PH_SYNC1;
                end
                PH_SYNC1:
                begin
                    sync_word_next[15:8] = s0_data_reg;
                    phase_next           = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    sync_word_next[23:16] = s0_data_reg;
                    phase_next            = PH_SYNC3;
                end
                PH_SYNC3:
                begin
                    sync_word_next = sync_full;
                    if (sync_full != ALL_ONES && (sync_full & sync_union_reg) != 32'd0)
                    begin
                        first_error_next = ERR_OVERLAP;
                    end
                    else
                    begin
                        if (sync_full != ALL_ONES)
                        begin
                            sync_union_next = sync_union_reg | sync_full;
                        end
                        phase_next = PH_MDLEN;
                    end
                end
                PH_MDLEN:
                begin
                    metadata_left_next = s0_data_reg;
                    if (s0_data_reg == 8'd0)
                    begin
                        subgroups_left_next = sg_dec;
                        phase_next = (sg_dec == 8'd0) ? PH_DONE : PH_SYNC0;
                    end
                    else
                    begin
                        phase_next = PH_META;
                    end
                end
                PH_META:
                begin
                    metadata_left_next = md_dec;
                    if (md_dec == 8'd0)
                    begin
                        subgroups_left_next = sg_dec;
                        phase_next = (sg_dec == 8'd0) ? PH_DONE : PH_SYNC0;
                    end
                end
                PH_DONE:
                begin
                    first_error_next = ERR_LENGTH;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        if (byte_count_reg <= CNT_W'(MAX_LEN))
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
        end

        priority if (byte_count_reg < CNT_W'(MIN_LEN - 1))
        begin
            verdict = ERR_SHORT;
        end
        else if (first_error_next != ERR_NONE)
        begin
            verdict = first_error_next;
        end
        else if (phase_next == PH_DONE)
        begin
            verdict = ERR_NONE;
        end
        else if (phase_next == PH_META)
        begin
            verdict = ERR_MD_OVERRUN;
        end
        else
        begin
            verdict = ERR_TRUNCATED;
        end

        if (s0_last_reg)
        begin
            phase_next          = PH_HEADER;
            byte_count_next     = '0;
            subgroups_left_next = 8'd0;
            sync_word_next      = 32'd0;
            sync_union_next     = 32'd0;
            metadata_left_next  = 8'd0;
            first_error_next    = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            byte_count_reg     <= '0;
            subgroups_left_reg <= 8'd0;
            sync_word_reg      <= 32'd0;
            sync_union_reg     <= 32'd0;
            metadata_left_reg  <= 8'd0;
            first_error_reg    <= ERR_NONE;
        end
        else if (s0_fire)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            subgroups_left_reg <= subgroups_left_next;
            sync_word_reg      <= sync_word_next;
            sync_union_reg     <= sync_union_next;
            metadata_left_reg  <= metadata_left_next;
            first_error_reg    <= first_error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_fire && s0_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_fire && s0_last_reg)
        begin
            accepted_reg   <= (verdict == ERR_NONE);
            error_code_reg <= verdict;
        end
    end

    `BSRV_ASSERT(a_verdict_consistent,
        out_valid_reg |-> (accepted_reg == (error_code_reg == ERR_NONE)),
        "accepted disagrees with error code")
    `BSRV_ASSERT(a_error_sticky,
        (first_error_reg != ERR_NONE && !s0_fire) |=>
            (first_error_reg == $past(first_error_reg)),
        "latched error changed without a byte")
    `BSRV_ASSERT(a_count_saturates,
        byte_count_reg <= CNT_W'(MAX_LEN + 1),
        "byte count beyond saturation")
    `BSRV_ASSERT(a_header_before_body,
        (phase_reg != PH_HEADER) |-> (byte_count_reg >= CNT_W'(MIN_LEN)),
        "record body entered before header end")
    `BSRV_ASSERT_ALWAYS(a_stall_needs_item,
        in_stall |-> s0_valid_reg,
        "input stalled with empty input register")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for broadcast_source_record_validator_top
// Streams add-source records one byte per transaction and checks each verdict
// against a byte-level model of the record layout or a pinned code. A table of
// hand-built records covers the limits and every error code. Random records
// follow, mostly well formed with an occasional flaw, under several register
// settings and with the sender and the receiver idling at different rates.
// ----------------------------------------------------------------------------
module testbench;
    import bsrv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN        = 255;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned ITEM_TARGET    = 1850;
    localparam int unsigned DIRECTED_BYTES = 1010;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_BYTES    = (ITEM_TARGET - DIRECTED_BYTES) / PHASES;
    localparam int unsigned DRAIN_LIMIT    = 2000;
    localparam int unsigned QUIET_CYCLES   = 8;
    localparam int unsigned TIMEOUT_NS     = 3_000_000;

    typedef enum {SYNC_DISJOINT, SYNC_ONES, SYNC_SAME, SYNC_MIXED} sync_mode_t;

    typedef struct {
        logic [7:0]  addr_type;
        logic [7:0]  sid;
        logic [7:0]  pa_sync;
        logic [7:0]  num_sub;
        int unsigned emit_sub;
        sync_mode_t  sync_mode;
        int unsigned md_lo;
        int unsigned md_hi;
        int unsigned cut;
        int unsigned extra;
        bit          fixed;
        err_t        want;
    } rec_spec_t;

    typedef struct {
        bit   fixed;
        err_t code;
    } pinned_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte  = 8'd0;
    logic       last_byte  = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       accepted;
    logic [3:0] error_code;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_index  = REG_MAX_ADDR_TYPE;
    logic [7:0] cfg_data   = 8'd0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;

    logic [7:0] cfg_addr_max = RST_MAX_ADDR_TYPE;
    logic [7:0] cfg_pa_first = RST_FIRST_RSV_PA;
    logic [5:0] cfg_sub_max  = RST_MAX_SUBGROUPS;

    phase_t      rec_phase    = PH_HEADER;
    logic [8:0]  rec_count    = '0;
    logic [7:0]  rec_sub_left = '0;
    logic [31:0] rec_word     = '0;
    logic [31:0] rec_union    = '0;
    logic [7:0]  rec_md_left  = '0;
    err_t        rec_err      = ERR_NONE;

    err_t       verdicts_due[$];
    pinned_t    pinned_verdicts[$];
    logic [7:0] rec_bytes[$];

    rec_spec_t directed_rows [25] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_NONE},
        '{8'd1,   8'd15,  8'd4,   8'd4,   4, SYNC_DISJOINT, 0,   3,   0,  0, 1'b1, ERR_NONE},
        '{8'd2,   8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_ADDR_TYPE},
        '{8'd255, 8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_ADDR_TYPE},
        '{8'd0,   8'd16,  8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_SID},
        '{8'd0,   8'd255, 8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_SID},
        '{8'd0,   8'd0,   8'd5,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_PA_SYNC},
        '{8'd0,   8'd0,   8'd255, 8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_PA_SYNC},
        '{8'd0,   8'd0,   8'd0,   8'd5,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_SUBGROUPS},
        '{8'd0,   8'd0,   8'd0,   8'd255, 0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_SUBGROUPS},
        '{8'd255, 8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   1,  0, 1'b1, ERR_SHORT},
        '{8'd0,   8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   14, 0, 1'b1, ERR_SHORT},
        '{8'd0,   8'd0,   8'd0,   8'd2,   2, SYNC_SAME,     0,   0,   0,  0, 1'b1, ERR_OVERLAP},
        '{8'd0,   8'd0,   8'd0,   8'd3,   3, SYNC_ONES,     0,   2,   0,  0, 1'b1, ERR_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 0,   0,   3,  0, 1'b1, ERR_TRUNCATED},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 0,   0,   1,  0, 1'b1, ERR_TRUNCATED},
        '{8'd0,   8'd0,   8'd0,   8'd2,   0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_TRUNCATED},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 5,   5,   2,  0, 1'b1, ERR_MD_OVERRUN},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 3,   3,   0,  2, 1'b1, ERR_LENGTH},
        '{8'd0,   8'd0,   8'd0,   8'd0,   0, SYNC_DISJOINT, 0,   0,   0,  1, 1'b1, ERR_LENGTH},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 235, 235, 0,  0, 1'b1, ERR_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, SYNC_DISJOINT, 255, 255, 0,  0, 1'b1, ERR_LENGTH},
        '{8'd255, 8'd255, 8'd255, 8'd255, 0, SYNC_DISJOINT, 0,   0,   0,  0, 1'b1, ERR_ADDR_TYPE},
        '{8'd1,   8'd15,  8'd4,   8'd4,   4, SYNC_MIXED,    0,   8,   0,  0, 1'b0, ERR_NONE},
        '{8'd0,   8'd3,   8'd2,   8'd3,   3, SYNC_MIXED,    0,   4,   0,  0, 1'b0, ERR_NONE}
    };

    broadcast_source_record_validator_top #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .error_code (error_code),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_record();
        rec_phase    = PH_HEADER;
        rec_count    = '0;
        rec_sub_left = '0;
        rec_word     = '0;
        rec_union    = '0;
        rec_md_left  = '0;
        rec_err      = ERR_NONE;
    endfunction

    function automatic void flag_error(input err_t code);
        if (rec_err == ERR_NONE)
        begin
            rec_err = code;
        end
    endfunction

    function automatic void close_subgroup();
        if (rec_sub_left != 0)
        begin
            rec_sub_left--;
        end
        rec_phase = (rec_sub_left == 0) ? PH_DONE : PH_SYNC0;
    endfunction

    function automatic void parse_byte(input int unsigned idx, input logic [7:0] b);
        int unsigned k;
        case (rec_phase)
            PH_HEADER:
            begin
                if (idx == IDX_ADDR_TYPE && b > cfg_addr_max)
                begin
                    flag_error(ERR_ADDR_TYPE);
                end
                else if (idx == IDX_SID && b > SID_MAX)
                begin
                    flag_error(ERR_SID);
                end
                else if (idx == IDX_PA_SYNC && b >= cfg_pa_first)
                begin
                    flag_error(ERR_PA_SYNC);
                end
                else if (idx == IDX_NUM_SUBGROUPS)
                begin
                    if (b > {2'b00, cfg_sub_max})
                    begin
                        flag_error(ERR_SUBGROUPS);
                    end
                    else
                    begin
                        rec_sub_left = b;
                        rec_union    = '0;
                        rec_word     = '0;
                        rec_phase    = (b == 0) ? PH_DONE : PH_SYNC0;
                    end
                end
            end
            PH_MDLEN:
            begin
                rec_md_left = b;
                if (b == 0)
                begin
                    close_subgroup();
                end
                else
                begin
                    rec_phase = PH_META;
                end
            end
            PH_META:
            begin
                if (rec_md_left != 0)
                begin
                    rec_md_left--;
                end
                if (rec_md_left == 0)
                begin
                    close_subgroup();
                end
            end
            PH_DONE:
            begin
                flag_error(ERR_LENGTH);
            end
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3:
            begin
                k = 32'(rec_phase) - 32'(PH_SYNC0);
                if (k == 0)
                begin
                    rec_word = '0;
                end
                rec_word |= {24'd0, b} << (8 * k);
                if (rec_phase == PH_SYNC3)
                begin
                    if (rec_word != ALL_ONES && (rec_word & rec_union) != 0)
                    begin
                        flag_error(ERR_OVERLAP);
                    end
                    else
                    begin
                        if (rec_word != ALL_ONES)
                        begin
                            rec_union |= rec_word;
                        end
                        rec_phase = PH_MDLEN;
                    end
                end
                else
                begin
                    rec_phase = phase_t'(rec_phase + 1);
                end
            end
            default:
            begin
                rec_phase = PH_HEADER;
            end
        endcase
    endfunction

    // Returns 1 when the byte closes a record, with the verdict in code.
    function automatic bit track_byte(input logic [7:0] b, input logic last,
                                      output err_t code);
        int unsigned idx;
        idx  = 32'(rec_count);
        code = ERR_NONE;
        if (idx >= MAX_LEN)
        begin
            flag_error(ERR_LENGTH);
        end
        else if (rec_err == ERR_NONE)
        begin
            parse_byte(idx, b);
        end
        if (rec_count <= MAX_LEN)
        begin
            rec_count++;
        end
        if (!last)
        begin
            return 1'b0;
        end
        if (idx + 1 < MIN_LEN)
        begin
            code = ERR_SHORT;
        end
        else if (rec_err != ERR_NONE)
        begin
            code = rec_err;
        end
        else if (rec_phase == PH_DONE)
        begin
            code = ERR_NONE;
        end
        else if (rec_phase == PH_META)
        begin
            code = ERR_MD_OVERRUN;
        end
        else
        begin
            code = ERR_TRUNCATED;
        end
        clear_record();
        return 1'b1;
    endfunction

    function automatic void build_record(input rec_spec_t s);
        logic [31:0] used;
        logic [31:0] w;
        int unsigned md;
        int unsigned left;
        rec_bytes.delete();
        repeat (MIN_LEN) rec_bytes.push_back(8'($urandom));
        rec_bytes[IDX_ADDR_TYPE]     = s.addr_type;
        rec_bytes[IDX_SID]           = s.sid;
        rec_bytes[IDX_PA_SYNC]       = s.pa_sync;
        rec_bytes[IDX_NUM_SUBGROUPS] = s.num_sub;
        used = '0;
        w    = ($urandom & 32'h7FFF_FFFF) | 32'h1;
        for (int g = 0; g < s.emit_sub; g++)
        begin
            case (s.sync_mode)
                SYNC_ONES:     w = ALL_ONES;
                SYNC_SAME:     w = w;
                SYNC_DISJOINT: w = $urandom & ~used;
                default:
                begin
                    case ($urandom_range(7))
                        0:       w = ALL_ONES;
                        1:       w = $urandom;
                        default: w = $urandom & ~used;
                    endcase
                end
            endcase
            if (w != ALL_ONES)
            begin
                used |= w;
            end
            for (int k = 0; k < 4; k++)
            begin
                rec_bytes.push_back(w[8 * k +: 8]);
            end
            md = $urandom_range(s.md_hi, s.md_lo);
            rec_bytes.push_back(8'(md));
            repeat (md) rec_bytes.push_back(8'($urandom));
        end
        repeat (s.extra) rec_bytes.push_back(8'($urandom));
        left = s.cut;
        while (left != 0 && rec_bytes.size() > 1)
        begin
            void'(rec_bytes.pop_back());
            left--;
        end
    endfunction

    task automatic send_record();
        for (int i = 0; i < rec_bytes.size(); i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid  <= 1'b0;
                data_byte <= 8'($urandom);
                last_byte <= 1'($urandom);
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= rec_bytes[i];
            last_byte <= (i == rec_bytes.size() - 1);
            do
            begin
                @(posedge clk);
            end
            while (in_stall);
            @(negedge clk);
        end
    endtask

    task automatic settle();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (verdicts_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (verdicts_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
            verdicts_due.delete();
            pinned_verdicts.delete();
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : watch
        err_t    code;
        err_t    want;
        pinned_t pin;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (track_byte(data_byte, last_byte, code))
                begin
                    if (pinned_verdicts.size() != 0)
                    begin
                        pin = pinned_verdicts.pop_front();
                        if (pin.fixed)
                        begin
                            code = pin.code;
                        end
                    end
                    verdicts_due.push_back(code);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("verdict arrived with none pending");
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (accepted !== (want == ERR_NONE))
                    begin
                        report_mismatch($sformatf("accepted %b, expected %b",
                                                  accepted, want == ERR_NONE));
                    end
                    if (error_code !== want)
                    begin
                        report_mismatch($sformatf("error_code %0d, expected %0d",
                                                  error_code, want));
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        rec_spec_t   spec;
        pinned_t     pin;
        int unsigned sent;
        int unsigned sub_cap;
        int unsigned flaw;
        logic [7:0]  addr_lim;
        logic [7:0]  pa_lim;
        logic [5:0]  sub_lim;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            pin.fixed = directed_rows[r].fixed;
            pin.code  = directed_rows[r].want;
            pinned_verdicts.push_back(pin);
            build_record(directed_rows[r]);
            send_record();
        end
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    addr_lim = RST_MAX_ADDR_TYPE;
                    pa_lim   = RST_FIRST_RSV_PA;
                    sub_lim  = RST_MAX_SUBGROUPS;
                end
                1:
                begin
                    addr_lim = 8'd255;
                    pa_lim   = 8'd255;
                    sub_lim  = 6'd32;
                end
                2:
                begin
                    addr_lim = 8'd0;
                    pa_lim   = 8'd0;
                    sub_lim  = 6'd0;
                end
                default:
                begin
                    addr_lim = 8'($urandom);
                    pa_lim   = 8'($urandom);
                    sub_lim  = 6'($urandom_range(32, 0));
                end
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= REG_MAX_ADDR_TYPE;
            cfg_data  <= addr_lim;
            @(negedge clk);
            cfg_index <= REG_FIRST_RSV_PA;
            cfg_data  <= pa_lim;
            @(negedge clk);
            cfg_index <= REG_MAX_SUBGROUPS;
            cfg_data  <= {2'b00, sub_lim};
            @(negedge clk);
            cfg_we       <= 1'b0;
            cfg_addr_max  = addr_lim;
            cfg_pa_first  = pa_lim;
            cfg_sub_max   = sub_lim;

            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 79;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase

            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(19) == 0)
                begin
                    rec_bytes.delete();
                    repeat ($urandom_range(30, 1)) rec_bytes.push_back(8'($urandom));
                end
                else
                begin
                    spec.addr_type = 8'($urandom_range(cfg_addr_max, 0));
                    spec.sid       = 8'($urandom_range(SID_MAX, 0));
                    spec.pa_sync   = (cfg_pa_first == 0)
                                     ? 8'($urandom)
                                     : 8'($urandom_range(cfg_pa_first - 1, 0));
                    sub_cap = ($urandom_range(3) == 0 || cfg_sub_max < 3)
                              ? 32'(cfg_sub_max) : 3;
                    spec.num_sub  = 8'($urandom_range(sub_cap, 0));
                    spec.emit_sub = 32'(spec.num_sub);
                    case ($urandom_range(9))
                        0:       spec.sync_mode = SYNC_ONES;
                        1:       spec.sync_mode = SYNC_DISJOINT;
                        default: spec.sync_mode = SYNC_MIXED;
                    endcase
                    spec.md_lo = 0;
                    spec.md_hi = ($urandom_range(9) == 0) ? 40 : 6;
                    if (cfg_sub_max != 0 && $urandom_range(59) == 0)
                    begin
                        spec.num_sub  = 8'd1;
                        spec.emit_sub = 1;
                        spec.md_lo    = 200;
                        spec.md_hi    = 255;
                    end
                    spec.cut   = 0;
                    spec.extra = 0;
                    spec.fixed = 1'b0;
                    spec.want  = ERR_NONE;
                    flaw = $urandom_range(99);
                    if (flaw < 5)
                    begin
                        spec.addr_type = 8'($urandom);
                    end
                    else if (flaw < 10)
                    begin
                        spec.sid = 8'($urandom);
                    end
                    else if (flaw < 15)
                    begin
                        spec.pa_sync = 8'($urandom);
                    end
                    else if (flaw < 20)
                    begin
                        spec.num_sub  = 8'($urandom);
                        spec.emit_sub = (spec.num_sub <= cfg_sub_max) ? 32'(spec.num_sub)
                                                                      : $urandom_range(2);
                    end
                    else if (flaw < 28)
                    begin
                        spec.cut = $urandom_range(12, 1);
                    end
                    else if (flaw < 33)
                    begin
                        spec.extra = $urandom_range(4, 1);
                    end
                    else if (flaw < 36)
                    begin
                        spec.cut = $urandom_range(20, 14);
                    end
                    build_record(spec);
                end
                send_record();
                sent += rec_bytes.size();
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("** broadcast_source_record_validator_top: PASSED **");
        end
        else
        begin
            $display("** broadcast_source_record_validator_top: FAILED **");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** broadcast_source_record_validator_top: FAILED **");
        $finish;
    end

endmodule
